// ----- rtl/core/copy_insert_delta_decoder_macros.svh -----
`ifndef COPY_INSERT_DELTA_DECODER_MACROS_SVH
`define COPY_INSERT_DELTA_DECODER_MACROS_SVH

// Same-cycle implication, checked on clk outside reset.
`define CIDD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk outside reset.
`define CIDD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/cidd_pkg.sv -----
package cidd_pkg;

  localparam int BASE_DEPTH = 16384;
  localparam int ADDR_W     = $clog2(BASE_DEPTH);
  localparam int FILL_W     = $clog2(BASE_DEPTH + 1);
  localparam int LEN_W      = 31;
  localparam int PTR_W      = 33;
  localparam int COUNT_W    = 24;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_DELTA = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
    logic       end_of_delta;
  } cidd_in_t;

  typedef struct packed {
    logic [7:0]         out_byte;
    logic               last;
    logic [COUNT_W-1:0] total_length;
    logic               fault;
  } cidd_out_t;

endpackage

// ----- rtl/core/copy_insert_delta_decoder.sv -----
// A result appears on result/strobe in the cycle after the item that causes it.
// Throughput: one item per cycle for every command; busy never rises.
// A copy byte is read from the base store on the tick's accept edge, through the
// store's registered read port.
// Reset (rst, synchronous) returns the parser, fill count and output count to idle;
// the base store keeps old contents, which never reach the output before being rewritten.
`include "copy_insert_delta_decoder_macros.svh"

module copy_insert_delta_decoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  cidd_pkg::cidd_in_t item,
  output logic               strobe,
  output cidd_pkg::cidd_out_t result
);

  import cidd_pkg::*;

  typedef enum logic [1:0] {PH_HEADER, PH_INSERT, PH_DRAIN} phase_t;

  phase_t             phase, phase_next;
  logic [FILL_W-1:0]  base_fill, base_fill_next;
  logic [55:0]        header_shift, header_shift_next;
  logic [3:0]         header_count, header_count_next;
  logic [LEN_W-1:0]   remaining_length, remaining_length_next;
  logic [PTR_W-1:0]   copy_pointer, copy_pointer_next;
  logic [COUNT_W-1:0] output_count, output_count_next;
  logic               stream_ended, stream_ended_next;

  logic               res_strobe, res_strobe_next;
  logic               res_from_ram, res_from_ram_next;
  logic [7:0]         res_byte, res_byte_next;
  logic               res_last, res_last_next;
  logic               res_fault, res_fault_next;
  logic [COUNT_W-1:0] res_count_next;
  logic [COUNT_W-1:0] res_count;

  logic               accept;
  logic               ram_we;
  logic [7:0]         ram_rdata;
  logic [7:0]         b;
  logic               eod;
  logic [31:0]        word;
  logic               finish;
  logic               emit;

  // Every item is taken on arrival.
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign b      = item.data_byte;
  assign eod    = item.end_of_delta;
  assign word   = {b, header_shift[23:0]};
  assign ram_we = accept && (item.command == CMD_LOAD) &&
                  (base_fill < FILL_W'(BASE_DEPTH));

  cidd_ram #(
    .WIDTH(8),
    .DEPTH(BASE_DEPTH)
  ) u_base_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(base_fill[ADDR_W-1:0]),
    .wdata(b),
    .raddr(copy_pointer[ADDR_W-1:0]),
    .rdata(ram_rdata)
  );

  always_comb begin
    phase_next            = phase;
    base_fill_next        = base_fill;
    header_shift_next     = header_shift;
    header_count_next     = header_count;
    remaining_length_next = remaining_length;
    copy_pointer_next     = copy_pointer;
    stream_ended_next     = stream_ended;
    finish                = 1'b0;
    emit                  = 1'b0;
    res_from_ram_next     = 1'b0;
    res_byte_next         = b;
    res_last_next         = 1'b0;
    res_fault_next        = 1'b0;

    if (accept) begin
      case (item.command)
        CMD_LOAD: begin
          if (ram_we) begin
            base_fill_next = base_fill + FILL_W'(1);
          end
        end
        CMD_DELTA: begin
          case (phase)
            PH_INSERT: begin
              remaining_length_next = remaining_length - LEN_W'(1);
              emit          = 1'b1;
              res_last_next = eod;
              if (remaining_length == LEN_W'(1)) begin
                phase_next = PH_HEADER;
              end
              finish = eod;
            end
            PH_HEADER: begin
              header_count_next = header_count + 4'd1;
              for (int i = 0; i < 7; i++) begin
                if (header_count == 4'(i)) begin
                  header_shift_next[8*i +: 8] = b;
                end
              end
              if (header_count == 4'd3 && b[7]) begin
                // insert header complete
                header_shift_next = '0;
                header_count_next = '0;
                if (eod) begin
                  finish = 1'b1;
                end else if (word[LEN_W-1:0] != '0) begin
                  phase_next            = PH_INSERT;
                  remaining_length_next = word[LEN_W-1:0];
                end
              end else if (header_count == 4'd7) begin
                // copy header complete: length, then offset
                header_shift_next = '0;
                header_count_next = '0;
                if (header_shift[LEN_W-1:0] != '0) begin
                  phase_next            = PH_DRAIN;
                  remaining_length_next = header_shift[LEN_W-1:0];
                  copy_pointer_next     = PTR_W'({b, header_shift[55:32]});
                  stream_ended_next     = eod;
                end else begin
                  finish = eod;
                end
              end else begin
                finish = eod;
              end
            end
            default: ;
          endcase
        end
        CMD_TICK: begin
          if (phase == PH_DRAIN) begin
            emit                  = 1'b1;
            res_from_ram_next     = 1'b1;
            res_fault_next        = copy_pointer >= PTR_W'(base_fill);
            res_last_next         = stream_ended && (remaining_length == LEN_W'(1));
            remaining_length_next = remaining_length - LEN_W'(1);
            copy_pointer_next     = copy_pointer + PTR_W'(1);
            if (remaining_length == LEN_W'(1)) begin
              if (stream_ended) begin
                finish = 1'b1;
              end else begin
                phase_next = PH_HEADER;
              end
            end
          end
        end
        default: ;
      endcase
    end

    res_count_next = (output_count != COUNT_MAX) ? output_count + COUNT_W'(1)
                                                 : output_count;
    output_count_next = emit ? res_count_next : output_count;
    res_strobe_next   = emit;

    if (finish) begin
      phase_next            = PH_HEADER;
      base_fill_next        = '0;
      header_shift_next     = '0;
      header_count_next     = '0;
      remaining_length_next = '0;
      copy_pointer_next     = '0;
      output_count_next     = '0;
      stream_ended_next     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HEADER;
      base_fill        <= '0;
      header_shift     <= '0;
      header_count     <= '0;
      remaining_length <= '0;
      copy_pointer     <= '0;
      output_count     <= '0;
      stream_ended     <= 1'b0;
      res_strobe       <= 1'b0;
    end else begin
      phase            <= phase_next;
      base_fill        <= base_fill_next;
      header_shift     <= header_shift_next;
      header_count     <= header_count_next;
      remaining_length <= remaining_length_next;
      copy_pointer     <= copy_pointer_next;
      output_count     <= output_count_next;
      stream_ended     <= stream_ended_next;
      res_strobe       <= res_strobe_next;
    end
    res_from_ram <= res_from_ram_next;
    res_byte     <= res_byte_next;
    res_last     <= res_last_next;
    res_fault    <= res_fault_next;
    res_count    <= res_count_next;
  end

  // Copy bytes come straight from the store's read register; on a fault they are replaced by zero.
  assign strobe              = res_strobe;
  assign result.out_byte     = res_from_ram ? (res_fault ? 8'd0 : ram_rdata) : res_byte;
  assign result.last         = res_last;
  assign result.total_length = res_count;
  assign result.fault        = res_fault;

  `CIDD_ASSERT_NEXT(a_load_silent, accept && item.command == CMD_LOAD, !strobe,
    "base load produced a result")
  `CIDD_ASSERT_NOW(a_fault_copy_only, strobe && result.fault, res_from_ram,
    "fault raised on a literal byte")
  `CIDD_ASSERT_NOW(a_fill_bound, 1'b1, base_fill <= FILL_W'(BASE_DEPTH),
    "base fill beyond store depth")
  `CIDD_ASSERT_NOW(a_drain_len, phase == PH_DRAIN || phase == PH_INSERT,
    remaining_length != '0, "record phase held with no bytes due")

endmodule

// ----- rtl/core/cidd_ram.sv -----
module cidd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
